>>> src/spr_pkg.sv
package spr_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_REG_W   = 5;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    // configuration register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_LOW    = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_REPLACE_LOW    = 3'd3,
        REG_REPLACE_HIGH   = 3'd4,
        REG_MAX_REPLACES   = 3'd5,
        REG_COUNT_ONLY     = 3'd6
    } cfg_reg_t;

    // one result as held in the output register
    typedef struct packed {
        byte_t  data;
        logic   last;
        count_t count;
    } result_t;

endpackage

>>> src/streaming_pattern_replace_core.sv
// Byte stream search and replace. Bytes enter on the s_axis side and leave in
// order on the m_axis side; every position where the last pattern_length
// bytes equal the programmed search pattern is a hit (leftmost first, hits
// never overlap), and in replace mode the hit bytes leave as the replacement
// pattern, while count mode leaves them untouched. The request with tlast set
// ends the buffer: the bytes still held in the window are flushed, the last
// output request carries tlast and the saturating hit count in tdata[39:8]
// (zero on all other requests), and the block starts fresh. Rate: one byte
// per cycle in steady state while the output accepts, set by the window compare
// between the input register and the output register. Bytes still in the window
// at the end of a buffer (up to pattern_length - 1) leave before the next buffer
// starts, and after pattern_length is lowered in the middle of a buffer the window
// drains down to one byte below the new length (empty for a zero length), one byte
// per cycle while the output accepts, before the next byte enters.
// Configuration is written through cfg_write_en / cfg_index / cfg_data while
// no request is in flight; writes do not disturb the window.
module streaming_pattern_replace_core
    import spr_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // input byte stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tlast,   // in_last

    // output byte stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [39:0]            m_axis_tdata,   // [7:0] out_byte, [39:8] hit_count
    output logic                   m_axis_tlast    // out_last
);

    // window index and fill widths follow from the window depth
    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int SKIP_W = IDX_W;

    // configuration registers
    logic [LEN_REG_W-1:0] pattern_length_reg;
    byte_t                pattern_reg [PATTERN_MAX];
    byte_t                replace_reg [PATTERN_MAX];
    count_t               max_replaces_reg;
    logic                 count_only_reg;

    // input register (skid between the input side and the window logic)
    logic                 in_valid_reg, in_valid_next;
    byte_t                in_byte_reg;
    logic                 in_last_reg;

    // window state, oldest byte in entry 0
    byte_t                window_reg [PATTERN_MAX];
    byte_t                window_next [PATTERN_MAX];
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [SKIP_W-1:0]    skip_reg, skip_next;
    count_t               hits_reg, hits_next;
    logic                 flush_reg, flush_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    // window datapath
    logic [FILL_W-1:0]    len_eff;
    logic [FILL_W-1:0]    len_m1;
    logic [FILL_W-1:0]    fill_push;
    byte_t                cand [PATTERN_MAX];
    byte_t                modified [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] byte_ok;
    logic                 match;
    logic                 limit_hit;
    logic                 do_check;
    logic                 do_pop;
    logic                 hit;
    count_t               hits_inc;

    // step control
    logic                 out_free;
    logic                 drain_need;
    logic                 proc_fire;
    logic                 drain_fire;
    logic                 flush_fire;
    logic                 pop_last;

    //--------------------------------------------------------------------
    // configuration
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            max_replaces_reg   <= '0;
            count_only_reg     <= 1'b0;
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                pattern_reg[i] <= '0;
                replace_reg[i] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_REG_W-1:0];
                REG_PATTERN_LOW:
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                    begin
                        if (i < 8)
                        begin
                            pattern_reg[i] <= cfg_data[8*(i & 7) +: 8];
                        end
                    end
                end
                REG_PATTERN_HIGH:
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                    begin
                        if (i >= 8)
                        begin
                            pattern_reg[i] <= cfg_data[8*(i & 7) +: 8];
                        end
                    end
                end
                REG_REPLACE_LOW:
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                    begin
                        if (i < 8)
                        begin
                            replace_reg[i] <= cfg_data[8*(i & 7) +: 8];
                        end
                    end
                end
                REG_REPLACE_HIGH:
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                    begin
                        if (i >= 8)
                        begin
                            replace_reg[i] <= cfg_data[8*(i & 7) +: 8];
                        end
                    end
                end
                REG_MAX_REPLACES:   max_replaces_reg <= cfg_data[COUNT_W-1:0];
                REG_COUNT_ONLY:     count_only_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // pattern length clamps to the window depth
    assign len_eff = (pattern_length_reg > LEN_REG_W'(PATTERN_MAX))
                   ? FILL_W'(PATTERN_MAX)
                   : pattern_length_reg[FILL_W-1:0];
    assign len_m1  = len_eff - FILL_W'(1);

    //--------------------------------------------------------------------
    // step selection
    //--------------------------------------------------------------------
    // a result register that empties this cycle can take a new byte
    assign out_free   = !out_valid_reg || m_axis_tready;
    // bytes left over from a longer pattern leave before the next one enters
    assign drain_need = (fill_reg != '0) && (fill_reg >= len_eff);

    assign flush_fire = flush_reg && out_free;
    assign drain_fire = !flush_reg && in_valid_reg && drain_need && out_free;
    assign proc_fire  = !flush_reg && in_valid_reg && !drain_need && out_free;

    assign s_axis_tready = !in_valid_reg || proc_fire;

    //--------------------------------------------------------------------
    // window compare
    //--------------------------------------------------------------------
    assign fill_push = fill_reg + FILL_W'(1);
    assign do_check  = (len_eff != '0) && (fill_push == len_eff);
    assign do_pop    = (len_eff == '0) || do_check;
    assign limit_hit = (max_replaces_reg != '0) && (hits_reg >= max_replaces_reg);

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            // the new byte lands at the fill position
            cand[i]    = (fill_reg == FILL_W'(i)) ? in_byte_reg : window_reg[i];
            byte_ok[i] = (FILL_W'(i) >= len_eff) || (cand[i] == pattern_reg[i]);
        end
    end

    assign match    = &byte_ok;
    assign hit      = do_check && (skip_reg == '0) && !limit_hit && match;
    assign hits_inc = hit ? ((hits_reg == '1) ? hits_reg : hits_reg + COUNT_W'(1))
                          : hits_reg;

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (hit && !count_only_reg && (FILL_W'(i) < len_eff))
            begin
                modified[i] = replace_reg[i];
            end
            else
            begin
                modified[i] = cand[i];
            end
        end
    end

    //--------------------------------------------------------------------
    // next state
    //--------------------------------------------------------------------
    always_comb
    begin
        window_next    = window_reg;
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        hits_next      = hits_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next       = out_reg;
        pop_last       = 1'b0;

        if (flush_fire)
        begin
            // end of buffer: one held byte per cycle while the output accepts, the final one carries the count
            out_valid_next = 1'b1;
            out_next.data  = window_reg[0];
            out_next.last  = 1'b0;
            out_next.count = '0;
            for (int i = 0; i < PATTERN_MAX - 1; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            fill_next = fill_reg - FILL_W'(1);
            if (fill_reg == FILL_W'(1))
            begin
                pop_last       = 1'b1;
                out_next.last  = 1'b1;
                out_next.count = hits_reg;
                hits_next      = '0;
                skip_next      = '0;
                flush_next     = 1'b0;
            end
        end
        else if (drain_fire)
        begin
            // unchecked byte beyond a lowered length, still uses up a skip
            out_valid_next = 1'b1;
            out_next.data  = window_reg[0];
            out_next.last  = 1'b0;
            out_next.count = '0;
            for (int i = 0; i < PATTERN_MAX - 1; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            fill_next = fill_reg - FILL_W'(1);
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - SKIP_W'(1);
            end
        end
        else if (proc_fire)
        begin
            hits_next = hits_inc;
            if (hit)
            begin
                skip_next = len_m1[SKIP_W-1:0];
            end
            else if (do_check && (skip_reg != '0))
            begin
                skip_next = skip_reg - SKIP_W'(1);
            end

            if (do_pop)
            begin
                out_valid_next = 1'b1;
                out_next.data  = modified[0];
                out_next.last  = 1'b0;
                out_next.count = '0;
                for (int i = 0; i < PATTERN_MAX - 1; i++)
                begin
                    window_next[i] = modified[i+1];
                end
                fill_next = fill_reg;
            end
            else
            begin
                window_next = modified;
                fill_next   = fill_push;
            end

            if (in_last_reg)
            begin
                if (do_pop && (fill_reg == '0))
                begin
                    // nothing left behind: this byte closes the buffer
                    pop_last       = 1'b1;
                    out_next.last  = 1'b1;
                    out_next.count = hits_inc;
                    hits_next      = '0;
                    skip_next      = '0;
                    fill_next      = '0;
                end
                else
                begin
                    flush_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg && !proc_fire;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
    end

    //--------------------------------------------------------------------
    // registers
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            skip_reg      <= '0;
            hits_reg      <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            hits_reg      <= hits_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        window_reg <= window_next;
        out_reg    <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.count, out_reg.data};
    assign m_axis_tlast  = out_reg.last;

    //--------------------------------------------------------------------
    // checks
    //--------------------------------------------------------------------
    // closing a buffer leaves a clean window behind
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_last |=> (fill_reg == '0 && skip_reg == '0 && hits_reg == '0))
    else $error("window not cleared after end of buffer");

    // the count only travels with the end-of-buffer byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[39:8] == '0))
    else $error("hit count on a byte that does not end the buffer");

    // a mid-buffer byte that pushes out the oldest keeps the fill level
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && do_pop && !in_last_reg) |=> $stable(fill_reg))
    else $error("fill level moved on a steady-state byte");

endmodule

>>> verif/tb.sv
module tb;
    import spr_pkg::*;

    localparam int PATTERN_MAX  = 16;
    localparam int IDLE_PCT     = 27;   // chance in a hundred that a side idles
    localparam int FLUSH_WAIT   = 2 * PATTERN_MAX + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 450;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } in_req_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [39:0]            m_axis_tdata;
    logic                   m_axis_tlast;

    streaming_pattern_replace_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow of the block: register copies and window state
    // ------------------------------------------------------------------
    logic [4:0]  cfg_len = '0;
    logic [63:0] cfg_pat_lo = '0;
    logic [63:0] cfg_pat_hi = '0;
    logic [63:0] cfg_rep_lo = '0;
    logic [63:0] cfg_rep_hi = '0;
    logic [31:0] cfg_max = '0;
    logic        cfg_count_only = 1'b0;

    logic [7:0]  win [PATTERN_MAX];
    int unsigned win_fill = 0;
    logic [3:0]  skip_left = '0;
    logic [31:0] hits_run = '0;

    in_req_t pending_bytes[$];   // requests not yet offered to the block
    result_t out_expected[$];    // output requests still owed by the block

    // bookkeeping shared between processes; the counters use nonblocking writes
    int bytes_in = 0;
    int bytes_out = 0;
    int buffers_out = 0;
    longint hits_seen = 0;
    int pressure_at = 32'h7fff_ffff;

    int      mismatches = 0;
    int      cfg_writes = 0;
    int      bytes_queued = 0;
    in_req_t drive_req;
    result_t seen_req;

    function automatic logic [7:0] lane(input logic [63:0] lo, input logic [63:0] hi,
                                        input int idx);
        logic [63:0] w;
        w = (idx < 8) ? lo : hi;
        return w[8*(idx%8) +: 8];
    endfunction

    function automatic int eff_len();
        return (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
    endfunction

    // oldest window byte leaves the block as a plain output request
    function automatic void emit_oldest();
        result_t r;
        r.data  = win[0];
        r.last  = 1'b0;
        r.count = '0;
        out_expected.push_back(r);
        for (int i = 0; i < PATTERN_MAX - 1; i++)
            win[i] = win[i+1];
        win_fill--;
    endfunction

    // decide whether the oldest byte starts a hit; rewrite the window if so
    function automatic void try_match(input int len);
        logic same;
        if (skip_left != 0)
        begin
            skip_left--;
            return;
        end
        if (cfg_max != 0 && hits_run >= cfg_max)
            return;
        same = 1'b1;
        for (int i = 0; i < len; i++)
            if (win[i] != lane(cfg_pat_lo, cfg_pat_hi, i))
                same = 1'b0;
        if (!same)
            return;
        if (!cfg_count_only)
            for (int i = 0; i < len; i++)
                win[i] = lane(cfg_rep_lo, cfg_rep_hi, i);
        if (hits_run != '1)
            hits_run++;
        skip_left = 4'(len - 1);
    endfunction

    // one accepted input request: work out the output requests it releases
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        int len;
        int tail;
        len = eff_len();
        // bytes beyond a lowered length leave unchecked, each eating a skip
        while (win_fill > 0 && win_fill >= len)
        begin
            if (skip_left != 0)
                skip_left--;
            emit_oldest();
        end
        win[win_fill] = b;
        win_fill++;
        if (len == 0)
            emit_oldest();
        else if (win_fill == len)
        begin
            try_match(len);
            emit_oldest();
        end
        if (last)
        begin
            // short tail never starts a hit, it just drains
            while (win_fill > 0)
                emit_oldest();
            tail = out_expected.size() - 1;
            out_expected[tail].last  = 1'b1;
            out_expected[tail].count = hits_run;
            win_fill  = 0;
            skip_left = '0;
            hits_run  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // input driver: feeds pending requests, predicts on each acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            bytes_in      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                bytes_in <= bytes_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                // no idle gaps on the input for a stretch of the random part
                if (pending_bytes.size() != 0 &&
                    ((bytes_in >= 200 && bytes_in < 300) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    drive_req = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drive_req.data;
                    s_axis_tlast  <= drive_req.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output ready: random stalls, one long hold-off, one stall-free stretch
    // ------------------------------------------------------------------
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && bytes_in >= pressure_at)
        begin
            // sender keeps offering while we hold, so the block backs up
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else if (bytes_out >= 250 && bytes_out < 400)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // output monitor: compare each request with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_out <= bytes_out + 1;
            if (m_axis_tlast)
            begin
                buffers_out <= buffers_out + 1;
                hits_seen   <= hits_seen + m_axis_tdata[39:8];
            end
            if (out_expected.size() == 0)
            begin
                $error("unexpected output request: out_byte %02h out_last %b hit_count %0d",
                       m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[39:8]);
                mismatches++;
            end
            else
            begin
                seen_req = out_expected.pop_front();
                if (m_axis_tdata[7:0] !== seen_req.data)
                begin
                    $error("out_byte: expected %02h, got %02h",
                           seen_req.data, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== seen_req.last)
                begin
                    $error("out_last: expected %b, got %b", seen_req.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tdata[39:8] !== seen_req.count)
                begin
                    $error("hit_count: expected %0d, got %0d",
                           seen_req.count, m_axis_tdata[39:8]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any accepted request or register write
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            cfg_write_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no progress for %0d cycles, %0d output requests still owed",
                   STALL_LIMIT, out_expected.size());
            $display("[streaming_pattern_replace_core] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            REG_PATTERN_LENGTH: cfg_len        = val[4:0];
            REG_PATTERN_LOW:    cfg_pat_lo     = val;
            REG_PATTERN_HIGH:   cfg_pat_hi     = val;
            REG_REPLACE_LOW:    cfg_rep_lo     = val;
            REG_REPLACE_HIGH:   cfg_rep_hi     = val;
            REG_MAX_REPLACES:   cfg_max        = val[31:0];
            REG_COUNT_ONLY:     cfg_count_only = val[0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic write_all(input logic [4:0] len, input logic [63:0] plo,
                             input logic [63:0] phi, input logic [63:0] rlo,
                             input logic [63:0] rhi, input logic [31:0] maxr,
                             input logic cnt);
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_PATTERN_LOW, plo);
        write_reg(REG_PATTERN_HIGH, phi);
        write_reg(REG_REPLACE_LOW, rlo);
        write_reg(REG_REPLACE_HIGH, rhi);
        write_reg(REG_MAX_REPLACES, 64'(maxr));
        write_reg(REG_COUNT_ONLY, 64'(cnt));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        in_req_t r;
        r.data = b;
        r.last = last;
        pending_bytes.push_back(r);
        bytes_queued++;
    endtask

    // wait until the block has drained, then give any flush time to finish
    task automatic settle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || out_expected.size() != 0);
        repeat (FLUSH_WAIT) @(negedge clk);
    endtask

    // mostly whole pattern copies with random noise and broken prefixes between
    task automatic queue_random_buffer(input int target, input logic close);
        int n;
        int kind;
        int k;
        int len;
        n = 0;
        len = eff_len();
        while (n < target)
        begin
            kind = $urandom_range(99);
            if (kind < 45 && len > 0)
            begin
                for (int i = 0; i < len; i++)
                    push_byte(lane(cfg_pat_lo, cfg_pat_hi, i), 1'b0);
                n += len;
            end
            else if (kind < 65 && len > 1)
            begin
                k = $urandom_range(len - 1, 1);
                for (int i = 0; i < k; i++)
                    push_byte(lane(cfg_pat_lo, cfg_pat_hi, i), 1'b0);
                push_byte(8'($urandom_range(255)), 1'b0);
                n += k + 1;
            end
            else
            begin
                if (len > 0 && $urandom_range(1) == 1)
                    push_byte(lane(cfg_pat_lo, cfg_pat_hi, $urandom_range(len - 1)), 1'b0);
                else
                    push_byte(8'($urandom_range(255)), 1'b0);
                n++;
            end
        end
        if (close)
            pending_bytes[pending_bytes.size()-1].last = 1'b1;
    endtask

    task automatic random_config();
        logic [4:0]  len;
        logic [31:0] maxr;
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0:       len = 5'd0;
            1:       len = 5'd16;
            2:       len = 5'($urandom_range(31, 17));   // saturates to the maximum
            9:       len = 5'($urandom_range(15, 6));
            default: len = 5'($urandom_range(5, 1));
        endcase
        pick = $urandom_range(9);
        if (pick < 6)
            maxr = '0;
        else if (pick < 9)
            maxr = 32'($urandom_range(3, 1));
        else
            maxr = '1;
        write_all(len,
                  ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom},
                  ($urandom_range(9) == 0) ? '0 : {$urandom, $urandom},
                  {$urandom, $urandom},
                  ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom},
                  maxr, 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int bufs;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero length: bytes pass straight through, registers at reset values
        write_all(5'd0, '0, '0, '0, '0, '0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();

        // replace mode: leftmost hit, then a tail too short to be a start
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_PATTERN_LOW, 64'h63_62_61);
        write_reg(REG_REPLACE_LOW, 64'h5A_59_58);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b1);
        settle();

        // count mode on a repeated byte: greedy hits never overlap
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_reg(REG_PATTERN_LOW, 64'h61_61);
        write_reg(REG_COUNT_ONLY, 64'd1);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b1);
        settle();

        // oversize length clamps to a full window; all-ones pattern, largest limit
        write_all(5'd31, '1, '1, '0, '0, '1, 1'b0);
        for (int i = 0; i < PATTERN_MAX; i++)
            push_byte(8'hFF, i == PATTERN_MAX - 1);
        settle();

        // hit leaves a skip pending, then the length drops mid-buffer
        write_all(5'd3, 64'h63_62_61, '0, 64'h5A_59_58, '0, '0, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'h78, 1'b0);
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        push_byte(8'h61, 1'b1);
        settle();

        // random phases; some end mid-buffer so the next setting lands inside it
        phase = 0;
        bytes_queued = 0;
        while (bytes_queued < RANDOM_BYTES)
        begin
            random_config();
            if (phase == 2)
            begin
                // long buffer while the receiver holds off
                pressure_at = bytes_in + 10;
                queue_random_buffer(90, 1'b1);
            end
            else
            begin
                bufs = $urandom_range(4, 1);
                for (int i = 0; i < bufs; i++)
                    queue_random_buffer($urandom_range(30, 1),
                                        (i < bufs - 1) || ($urandom_range(9) < 7));
            end
            settle();
            phase++;
        end

        // close whatever buffer is still open
        push_byte(8'($urandom_range(255)), 1'b1);
        settle();

        $display("run covered %0d input bytes and %0d output bytes over %0d buffers",
                 bytes_in, bytes_out, buffers_out);
        $display("%0d hits reported, %0d register writes across %0d random settings",
                 hits_seen, cfg_writes, phase);
        if (mismatches == 0)
            $display("[streaming_pattern_replace_core] OK");
        else
            $display("[streaming_pattern_replace_core] ERROR");
        $finish;
    end

endmodule
